// ===== src/assert_macros.svh =====
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Flag a condition that must never be seen on a clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ===== src/drdo_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package drdo_pkg;

  localparam int SINE_ENTRIES_DEF = 256;

  localparam int TIME_W = 32;
  localparam int MAG_W  = 16;
  localparam int SINE_W = 16;
  localparam int POS_W  = 48;
  localparam int HEAD_W = 16;
  localparam int HACC_W = 32;

  // product widths: |speed|*|sin|, |speed|*dt, |speed|*|sin|*dt
  localparam int PSC_W = MAG_W + SINE_W - 1;
  localparam int PDT_W = MAG_W + TIME_W;
  localparam int MXY_W = PSC_W + TIME_W;

  // position deltas and sums before saturation
  localparam int DELTA_W = POS_W + 2;

  // x/y: 2/1e6 = 1/500000 = 2^-5/15625; distance and heading: 65536/1e6 = 1024/15625
  localparam int X_SHIFT   = 5;
  localparam int D_DIVISOR = 15625;
  localparam int D_SHIFT   = 10;

  // floor(n / D_DIVISOR) = (n * D_RECIP) >> DIV_SHIFT for every n below 2^DIV_W,
  // with D_RECIP the reciprocal rounded up
  localparam int DIV_W      = 58;
  localparam int DIV_HALF_W = DIV_W / 2;
  localparam int DIV_SHIFT  = DIV_W + $clog2(D_DIVISOR);
  localparam int RCP_W      = 60;
  localparam int RCP_HALF_W = RCP_W / 2;
  localparam logic [RCP_W-1:0] D_RECIP =
    RCP_W'((128'd1 << DIV_SHIFT) / 128'(D_DIVISOR) + 128'd1);
  localparam int ACC_W      = DIV_W + RCP_W;
  localparam int QUO_W      = ACC_W - DIV_SHIFT;

  // one partial product of the reciprocal multiply per step
  localparam int DIV_CYCLES = 4;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam int QUEUE_DEPTH = 2;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint TAYLOR_DIV [7] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72,
                                       64'sd110, 64'sd156, 64'sd210};

  typedef struct packed {
    logic [TIME_W-1:0] dt;
    logic [MAG_W-1:0]  speed_mag;
    logic              speed_neg;
    logic [MAG_W-1:0]  rate_mag;
    logic              rate_neg;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_DIV,
    B_UPD
  } back_state_e;

  // Q15 sine of a Q30 angle: truncating Taylor sum up to x^15, rounded half up.
  function automatic logic [SINE_W-1:0] sine_entry(input longint x);
    longint x2;
    longint term;
    longint sum;
    longint v;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    for (int k = 0; k < 7; k++) begin
      term = -(term * x2) / ONE_Q30;
      term = term / TAYLOR_DIV[k];
      sum  = sum + term;
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    v = (sum * 32767 + ONE_Q30 / 2) >>> 30;
    if (v > 32767) v = 32767;
    return SINE_W'(v);
  endfunction

endpackage

`default_nettype wire

// ===== src/drdo_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module drdo_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [drdo_pkg::TIME_W-1:0]     now_us_i,
  input  logic signed [drdo_pkg::MAG_W-1:0] forward_speed_i,
  input  logic signed [drdo_pkg::MAG_W-1:0] turn_rate_i,
  input  drdo_pkg::queue_status_t         q_status_i,
  output logic                            q_push_o,
  output drdo_pkg::item_t                 q_item_o
);

  logic [drdo_pkg::TIME_W-1:0] last_q, last_d;

  assign in_stall_o = q_status_i.full;
  assign q_push_o   = in_valid_i && !q_status_i.full;

  // split each rate into magnitude and sign; dt wraps modulo 2^32
  always_comb begin
    q_item_o.dt        = now_us_i - last_q;
    q_item_o.speed_neg = forward_speed_i[drdo_pkg::MAG_W-1];
    q_item_o.speed_mag = forward_speed_i[drdo_pkg::MAG_W-1] ?
                         (~forward_speed_i + 16'd1) : forward_speed_i;
    q_item_o.rate_neg  = turn_rate_i[drdo_pkg::MAG_W-1];
    q_item_o.rate_mag  = turn_rate_i[drdo_pkg::MAG_W-1] ?
                         (~turn_rate_i + 16'd1) : turn_rate_i;
  end

  assign last_d = q_push_o ? now_us_i : last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/drdo_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module drdo_fifo (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  drdo_pkg::item_t         item_i,
  input  logic                    pop_i,
  output drdo_pkg::item_t         item_o,
  output drdo_pkg::queue_status_t status_o
);

  localparam int PTR_W = (drdo_pkg::QUEUE_DEPTH > 1) ? $clog2(drdo_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(drdo_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(drdo_pkg::QUEUE_DEPTH - 1);

  drdo_pkg::item_t   entry_q [drdo_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign status_o.full  = (count_q == CNT_W'(drdo_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign item_o         = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/drdo_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Unsigned divide by the fixed divisor: multiply by the rounded-up reciprocal and
// keep the top bits. The product builds up from four partial products, one per step.
module drdo_div (
  input  logic                           clk_i,
  input  logic                           load_i,
  input  logic                           step_i,
  input  logic [drdo_pkg::DIV_CNT_W-1:0] part_i,
  input  logic [drdo_pkg::DIV_W-1:0]     dividend_i,
  output logic [drdo_pkg::QUO_W-1:0]     quot_o
);

  localparam int HN   = drdo_pkg::DIV_HALF_W;
  localparam int HM   = drdo_pkg::RCP_HALF_W;
  localparam int PP_W = HN + HM;
  localparam int ACC_W = drdo_pkg::ACC_W;
  localparam logic [HM-1:0] RCP_LO = HM'(drdo_pkg::D_RECIP);
  localparam logic [HM-1:0] RCP_HI = HM'(drdo_pkg::D_RECIP >> HM);

  logic [drdo_pkg::DIV_W-1:0] num_q;
  logic [ACC_W-1:0]           acc_q;
  logic [HN-1:0]              n_part;
  logic [HM-1:0]              m_part;
  logic [PP_W-1:0]            pp;
  logic [ACC_W-1:0]           pp_ext;

  // bit 0 of the step picks the dividend half, bit 1 the reciprocal half
  always_comb begin
    n_part = part_i[0] ? num_q[drdo_pkg::DIV_W-1:HN] : num_q[HN-1:0];
    m_part = part_i[1] ? RCP_HI : RCP_LO;
    pp     = n_part * m_part;
    pp_ext = ACC_W'(pp);
    if (part_i[0]) pp_ext = pp_ext << HN;
    if (part_i[1]) pp_ext = pp_ext << HM;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q <= dividend_i;
      acc_q <= '0;
    end else if (step_i) begin
      acc_q <= acc_q + pp_ext;
    end
  end

  assign quot_o = acc_q[ACC_W-1:drdo_pkg::DIV_SHIFT];

endmodule

`default_nettype wire

// ===== src/drdo_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module drdo_back #(
  parameter int SINE_TABLE_ENTRIES = drdo_pkg::SINE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  drdo_pkg::queue_status_t           q_status_i,
  input  drdo_pkg::item_t                   q_item_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [drdo_pkg::POS_W-1:0] x_pos_o,
  output logic signed [drdo_pkg::POS_W-1:0] y_pos_o,
  output logic signed [drdo_pkg::POS_W-1:0] distance_o,
  output logic [drdo_pkg::HEAD_W-1:0]       heading_o
);

  localparam int IDX_W  = $clog2(4 * SINE_TABLE_ENTRIES);
  localparam int R_W    = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int PROD_W = drdo_pkg::HACC_W + IDX_W;
  localparam int POS_W  = drdo_pkg::POS_W;
  localparam int DEL_W  = drdo_pkg::DELTA_W;
  localparam int MAG15  = drdo_pkg::SINE_W - 1;
  localparam logic [drdo_pkg::DIV_CNT_W-1:0] DIV_LAST =
    drdo_pkg::DIV_CNT_W'(drdo_pkg::DIV_CYCLES - 1);

  // quarter-wave table, built at elaboration
  logic [drdo_pkg::SINE_W-1:0] sine_lut [SINE_TABLE_ENTRIES + 1];

  for (genvar g = 0; g <= SINE_TABLE_ENTRIES; g++) begin : g_lut
    localparam longint ANGLE =
      (drdo_pkg::HALF_PI_Q30 * g + SINE_TABLE_ENTRIES / 2) / SINE_TABLE_ENTRIES;
    localparam logic [drdo_pkg::SINE_W-1:0] ENTRY = drdo_pkg::sine_entry(ANGLE);
    assign sine_lut[g] = ENTRY;
  end

  drdo_pkg::back_state_e state_q, state_d;

  drdo_pkg::item_t               item_q;
  logic [MAG15-1:0]              sin_mag_q, cos_mag_q;
  logic                          sin_neg_q, cos_neg_q;
  logic [drdo_pkg::PSC_W-1:0]    p_sx_q, p_cy_q;
  logic [drdo_pkg::PDT_W-1:0]    p_d_q, p_h_q;
  logic [drdo_pkg::DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

  logic signed [POS_W-1:0]       x_acc_q, x_acc_d;
  logic signed [POS_W-1:0]       y_acc_q, y_acc_d;
  logic signed [POS_W-1:0]       d_acc_q, d_acc_d;
  logic [drdo_pkg::HACC_W-1:0]   h_acc_q, h_acc_d;
  logic                          out_valid_q, out_valid_d;

  logic mul1_en, div_load, div_step, upd;

  // ---------------------------------------------------------------- sine lookup
  logic [PROD_W-1:0] idx_prod;
  logic [IDX_W-1:0]  idx, idx_rem;
  logic [1:0]        quad;
  logic [R_W-1:0]    r_idx, r_mir;
  logic [drdo_pkg::SINE_W-1:0] lut_lo, lut_hi;

  assign idx_prod = {{IDX_W{1'b0}}, h_acc_q} * PROD_W'(4 * SINE_TABLE_ENTRIES);
  assign idx      = idx_prod[PROD_W-1:drdo_pkg::HACC_W];

  always_comb begin
    if (idx < IDX_W'(SINE_TABLE_ENTRIES)) begin
      quad    = 2'd0;
      idx_rem = idx;
    end else if (idx < IDX_W'(2 * SINE_TABLE_ENTRIES)) begin
      quad    = 2'd1;
      idx_rem = idx - IDX_W'(SINE_TABLE_ENTRIES);
    end else if (idx < IDX_W'(3 * SINE_TABLE_ENTRIES)) begin
      quad    = 2'd2;
      idx_rem = idx - IDX_W'(2 * SINE_TABLE_ENTRIES);
    end else begin
      quad    = 2'd3;
      idx_rem = idx - IDX_W'(3 * SINE_TABLE_ENTRIES);
    end
  end

  assign r_idx  = R_W'(idx_rem);
  assign r_mir  = R_W'(SINE_TABLE_ENTRIES) - r_idx;
  assign lut_lo = sine_lut[r_idx];
  assign lut_hi = sine_lut[r_mir];

  // ---------------------------------------------------------------- dividers
  logic [drdo_pkg::MXY_W-1:0] mx, my;
  logic [drdo_pkg::QUO_W-1:0] quot_x, quot_y, quot_d, quot_h;

  assign mx = p_sx_q * item_q.dt;
  assign my = p_cy_q * item_q.dt;

  drdo_div u_div_x (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .part_i     (div_cnt_q),
    .dividend_i (drdo_pkg::DIV_W'(mx[drdo_pkg::MXY_W-1:drdo_pkg::X_SHIFT])),
    .quot_o     (quot_x)
  );

  drdo_div u_div_y (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .part_i     (div_cnt_q),
    .dividend_i (drdo_pkg::DIV_W'(my[drdo_pkg::MXY_W-1:drdo_pkg::X_SHIFT])),
    .quot_o     (quot_y)
  );

  drdo_div u_div_d (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .part_i     (div_cnt_q),
    .dividend_i (drdo_pkg::DIV_W'({p_d_q, {drdo_pkg::D_SHIFT{1'b0}}})),
    .quot_o     (quot_d)
  );

  drdo_div u_div_h (
    .clk_i      (clk_i),
    .load_i     (div_load),
    .step_i     (div_step),
    .part_i     (div_cnt_q),
    .dividend_i (drdo_pkg::DIV_W'({p_h_q, {drdo_pkg::D_SHIFT{1'b0}}})),
    .quot_o     (quot_h)
  );

  // ---------------------------------------------------------------- update
  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [DEL_W-1:0] v);
    if (v[DEL_W-1:POS_W-1] == '0 || v[DEL_W-1:POS_W-1] == '1) begin
      sat_pos = v[POS_W-1:0];
    end else if (v[DEL_W-1]) begin
      sat_pos = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat_pos = {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  logic signed [DEL_W-1:0] qx, qy, qd;
  logic signed [DEL_W-1:0] dx, dy, dd;
  logic signed [DEL_W-1:0] x_sum, y_sum, d_sum;
  logic [drdo_pkg::HACC_W-1:0] qh, dh;

  assign qx = $signed(DEL_W'(quot_x));
  assign qy = $signed(DEL_W'(quot_y));
  assign qd = $signed(DEL_W'(quot_d));
  assign qh = quot_h[drdo_pkg::HACC_W-1:0];

  // quotients are magnitudes; apply the sign so the result truncates toward zero
  assign dx = (item_q.speed_neg ^ sin_neg_q) ? -qx : qx;
  assign dy = (item_q.speed_neg ^ cos_neg_q) ? -qy : qy;
  assign dd = item_q.speed_neg ? -qd : qd;
  assign dh = item_q.rate_neg ? -qh : qh;

  assign x_sum = $signed({{(DEL_W-POS_W){x_acc_q[POS_W-1]}}, x_acc_q}) - dx;
  assign y_sum = $signed({{(DEL_W-POS_W){y_acc_q[POS_W-1]}}, y_acc_q}) + dy;
  assign d_sum = $signed({{(DEL_W-POS_W){d_acc_q[POS_W-1]}}, d_acc_q}) + dd;

  always_comb begin
    x_acc_d = x_acc_q;
    y_acc_d = y_acc_q;
    d_acc_d = d_acc_q;
    h_acc_d = h_acc_q;
    if (upd) begin
      x_acc_d = sat_pos(x_sum);
      y_acc_d = sat_pos(y_sum);
      d_acc_d = sat_pos(d_sum);
      h_acc_d = h_acc_q + dh;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (upd) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drdo_pkg::B_IDLE: begin
        if (!q_status_i.empty) state_d = drdo_pkg::B_MUL1;
      end
      drdo_pkg::B_MUL1: state_d = drdo_pkg::B_MUL2;
      drdo_pkg::B_MUL2: state_d = drdo_pkg::B_DIV;
      drdo_pkg::B_DIV: begin
        if (div_cnt_q == DIV_LAST) state_d = drdo_pkg::B_UPD;
      end
      drdo_pkg::B_UPD: begin
        if (!(out_valid_q && out_stall_i)) state_d = drdo_pkg::B_IDLE;
      end
      default: state_d = drdo_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o  = 1'b0;
    mul1_en  = 1'b0;
    div_load = 1'b0;
    div_step = 1'b0;
    upd      = 1'b0;
    unique case (state_q)
      drdo_pkg::B_IDLE: q_pop_o  = !q_status_i.empty;
      drdo_pkg::B_MUL1: mul1_en  = 1'b1;
      drdo_pkg::B_MUL2: div_load = 1'b1;
      drdo_pkg::B_DIV:  div_step = 1'b1;
      // hold the new result until the previous one is taken
      drdo_pkg::B_UPD:  upd      = !(out_valid_q && out_stall_i);
      default: ;
    endcase
  end

  always_comb begin
    div_cnt_d = div_cnt_q;
    if (div_load) begin
      div_cnt_d = '0;
    end else if (div_step) begin
      div_cnt_d = div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q    <= q_item_i;
      sin_mag_q <= quad[0] ? lut_hi[MAG15-1:0] : lut_lo[MAG15-1:0];
      cos_mag_q <= quad[0] ? lut_lo[MAG15-1:0] : lut_hi[MAG15-1:0];
      sin_neg_q <= quad[1];
      cos_neg_q <= quad[1] ^ quad[0];
    end
    if (mul1_en) begin
      p_sx_q <= item_q.speed_mag * sin_mag_q;
      p_cy_q <= item_q.speed_mag * cos_mag_q;
      p_d_q  <= item_q.speed_mag * item_q.dt;
      p_h_q  <= item_q.rate_mag * item_q.dt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drdo_pkg::B_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      d_acc_q     <= '0;
      h_acc_q     <= '0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      x_acc_q     <= x_acc_d;
      y_acc_q     <= y_acc_d;
      d_acc_q     <= d_acc_d;
      h_acc_q     <= h_acc_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_pos_o     = x_acc_q;
  assign y_pos_o     = y_acc_q;
  assign distance_o  = d_acc_q;
  assign heading_o   = h_acc_q[drdo_pkg::HACC_W-1 -: drdo_pkg::HEAD_W];

endmodule

`default_nettype wire

// ===== src/dead_reckoning_odometry_top.sv =====
// Dead-reckoning odometry for a unicycle vehicle. Each item carries a
// microsecond timestamp, a signed forward speed (mm/s) and a signed turn
// rate (turn/65536 per second); the block integrates them over the time
// since the previous item (the first item after reset measures from zero)
// and returns one result per item: x and y position and travelled distance
// as saturating signed Q31.16 mm, and the heading as turn/65536, using the
// heading held before the item for sine and cosine. Items are taken into a
// two-entry queue while the back end works, so the input keeps flowing while
// a result waits on a stalled output, until the queue is full. For each item
// the back end takes it and reads the sine table, runs two multiply stages,
// four steps of the reciprocal-multiply dividers (one partial product per step)
// and updates the accumulators once any earlier result is taken; it takes no
// new item before the update of the last one is done.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module dead_reckoning_odometry_top #(
  parameter int SINE_TABLE_ENTRIES = drdo_pkg::SINE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [drdo_pkg::TIME_W-1:0]       now_us_i,
  input  logic signed [drdo_pkg::MAG_W-1:0] forward_speed_i,
  input  logic signed [drdo_pkg::MAG_W-1:0] turn_rate_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [drdo_pkg::POS_W-1:0] x_pos_o,
  output logic signed [drdo_pkg::POS_W-1:0] y_pos_o,
  output logic signed [drdo_pkg::POS_W-1:0] distance_o,
  output logic [drdo_pkg::HEAD_W-1:0]       heading_o
);

  drdo_pkg::queue_status_t q_status;
  drdo_pkg::item_t         q_in_item;
  drdo_pkg::item_t         q_out_item;
  logic                    q_push;
  logic                    q_pop;

  drdo_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .now_us_i        (now_us_i),
    .forward_speed_i (forward_speed_i),
    .turn_rate_i     (turn_rate_i),
    .q_status_i      (q_status),
    .q_push_o        (q_push),
    .q_item_o        (q_in_item)
  );

  drdo_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .item_i   (q_in_item),
    .pop_i    (q_pop),
    .item_o   (q_out_item),
    .status_o (q_status)
  );

  drdo_back #(
    .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_item_i    (q_out_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_pos_o     (x_pos_o),
    .y_pos_o     (y_pos_o),
    .distance_o  (distance_o),
    .heading_o   (heading_o)
  );

  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && q_status.empty, "queue popped while empty")
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, q_push && q_status.full, "queue pushed while full")
  `ASSERT_CLK(a_result_moves, clk_i, rst_ni, (!$stable(x_pos_o) || !$stable(y_pos_o) || !$stable(distance_o) || !$stable(heading_o)) |-> out_valid_o, "result changed without valid")

endmodule

`default_nettype wire

// ===== tb/tb_dead_reckoning_odometry_top.sv =====
`timescale 1ns / 1ps

module tb_dead_reckoning_odometry_top;

  localparam int     N           = drdo_pkg::SINE_ENTRIES_DEF;
  localparam longint HALF_PI     = 64'sd1686629713;
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint US_PER_S    = 64'sd1000000;
  localparam longint FRAC_NUM    = 64'sd1024;
  localparam longint FRAC_DEN    = 64'sd15625;
  localparam longint POS_MAX     = 64'sd140737488355327;
  localparam longint POS_MIN     = -POS_MAX - 64'sd1;
  localparam logic signed [drdo_pkg::MAG_W-1:0] SPEED_MAX = 16'sh7FFF;
  localparam logic signed [drdo_pkg::MAG_W-1:0] SPEED_MIN = 16'sh8000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     SHOW_LIMIT  = 10;

  typedef struct packed {
    logic [drdo_pkg::POS_W-1:0]  x;
    logic [drdo_pkg::POS_W-1:0]  y;
    logic [drdo_pkg::POS_W-1:0]  travel;
    logic [drdo_pkg::HEAD_W-1:0] heading;
  } pose_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [drdo_pkg::TIME_W-1:0]       now_us_i;
  logic signed [drdo_pkg::MAG_W-1:0] forward_speed_i;
  logic signed [drdo_pkg::MAG_W-1:0] turn_rate_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [drdo_pkg::POS_W-1:0] x_pos_o;
  logic signed [drdo_pkg::POS_W-1:0] y_pos_o;
  logic signed [drdo_pkg::POS_W-1:0] distance_o;
  logic [drdo_pkg::HEAD_W-1:0]       heading_o;

  // odometry state as the block should hold it
  logic [drdo_pkg::TIME_W-1:0] odo_last_time;
  longint                      odo_x;
  longint                      odo_y;
  longint                      odo_dist;
  logic [drdo_pkg::HACC_W-1:0] odo_heading;
  int                          sine_rom [0:N];

  pose_t pose_q [$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int items_sent;
  int results_seen;
  int rail_hits;
  int err_cnt;

  dead_reckoning_odometry_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .now_us_i        (now_us_i),
    .forward_speed_i (forward_speed_i),
    .turn_rate_i     (turn_rate_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .x_pos_o         (x_pos_o),
    .y_pos_o         (y_pos_o),
    .distance_o      (distance_o),
    .heading_o       (heading_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[dead_reckoning_odometry_top] ERROR");
    $finish;
  end

  // Q15 quarter-wave entry: truncating Taylor sum in Q30, rounded half up
  function automatic int sine_q15(input int i);
    longint ang;
    longint ang2;
    longint term;
    longint acc;
    longint v;
    ang  = (HALF_PI * i + N / 2) / N;
    ang2 = (ang * ang) >>> 30;
    term = ang;
    acc  = ang;
    for (int k = 1; k <= 7; k++) begin
      term = -(term * ang2) / Q30_ONE;
      term = term / ((2 * k) * (2 * k + 1));
      acc  = acc + term;
    end
    if (acc < 0) acc = 0;
    if (acc > Q30_ONE) acc = Q30_ONE;
    v = (acc * 32767 + Q30_ONE / 2) >>> 30;
    if (v > 32767) v = 32767;
    return int'(v);
  endfunction

  function automatic longint sine_lookup(input logic [63:0] idx);
    logic [63:0] wrapped;
    logic [63:0] quad;
    logic [63:0] rem;
    wrapped = idx % (4 * N);
    quad    = wrapped / N;
    rem     = wrapped % N;
    case (quad)
      64'd0:   return longint'(sine_rom[rem]);
      64'd1:   return longint'(sine_rom[N - rem]);
      64'd2:   return -longint'(sine_rom[rem]);
      default: return -longint'(sine_rom[N - rem]);
    endcase
  endfunction

  function automatic longint pos_clamp(input longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  // integrate one accepted item and queue the pose it must produce
  task automatic advance_odometry(input logic [drdo_pkg::TIME_W-1:0] now,
                                  input logic signed [drdo_pkg::MAG_W-1:0] spd,
                                  input logic signed [drdo_pkg::MAG_W-1:0] rt);
    logic [drdo_pkg::TIME_W-1:0] dt32;
    logic [63:0]                 idx;
    longint                      dt;
    longint                      sp;
    longint                      rr;
    longint                      s;
    longint                      c;
    longint                      dx;
    longint                      dy;
    longint                      dd;
    longint                      dh;
    pose_t                       want;
    dt32 = now - odo_last_time;
    dt   = dt32;
    sp   = spd;
    rr   = rt;
    idx  = (64'(odo_heading) * 64'(4 * N)) >> 32;
    s    = sine_lookup(idx);
    c    = sine_lookup(idx + N);
    dx   = (sp * s * dt * 2) / US_PER_S;
    dy   = (sp * c * dt * 2) / US_PER_S;
    dd   = (sp * dt * FRAC_NUM) / FRAC_DEN;
    dh   = (rr * dt * FRAC_NUM) / FRAC_DEN;
    odo_x         = pos_clamp(odo_x - dx);
    odo_y         = pos_clamp(odo_y + dy);
    odo_dist      = pos_clamp(odo_dist + dd);
    odo_heading   = odo_heading + dh[31:0];
    odo_last_time = now;
    want.x       = odo_x[drdo_pkg::POS_W-1:0];
    want.y       = odo_y[drdo_pkg::POS_W-1:0];
    want.travel  = odo_dist[drdo_pkg::POS_W-1:0];
    want.heading = odo_heading[31:16];
    pose_q.push_back(want);
  endtask

  // valid stays high after accept; the next call either idles or reloads it
  task automatic send_item(input logic [drdo_pkg::TIME_W-1:0] now,
                           input logic signed [drdo_pkg::MAG_W-1:0] spd,
                           input logic signed [drdo_pkg::MAG_W-1:0] rt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    now_us_i        <= now;
    forward_speed_i <= spd;
    turn_rate_i     <= rt;
    do @(posedge clk_i); while (in_stall_o);
    advance_odometry(now, spd, rt);
    items_sent++;
  endtask

  function automatic logic [drdo_pkg::MAG_W-1:0] pick_signed16();
    case ($urandom_range(9))
      7:       return SPEED_MAX;
      8:       return SPEED_MIN;
      9:       return 16'($urandom_range(200)) - 16'd100;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random_item();
    logic [drdo_pkg::TIME_W-1:0] now;
    int                          pick;
    pick = $urandom_range(9);
    if (pick < 5) now = odo_last_time + $urandom_range(20000);
    else if (pick < 8) now = odo_last_time + $urandom_range(2000000);
    else now = $urandom();
    send_item(now, pick_signed16(), pick_signed16());
  endtask

  task automatic test_directed();
    send_item(32'd500000, 16'sd1000, 16'sd16384);   // first item measures from zero
    send_item(32'd500000, SPEED_MIN, SPEED_MIN);     // zero elapsed time
    send_item(32'd500001, SPEED_MAX, SPEED_MAX);
    send_item(32'hFFFF_FFFF, -16'sd1, 16'sd1);
    send_item(32'd100, SPEED_MAX, SPEED_MIN);        // timestamp wraps
    send_item(odo_last_time - 32'd1, SPEED_MIN, SPEED_MAX);
    // eighth-turn steps walk the heading through every quadrant
    for (int k = 0; k < 8; k++)
      send_item(odo_last_time + 32'd1000000, 16'sd1234, 16'sd8192);
    send_item(32'hAAAA_AAAA, 16'sh5555, 16'shAAAA);
    send_item(32'h5555_5555, 16'shAAAA, 16'sh5555);
    send_item(32'h0000_0000, 16'sh0000, 16'sh0000);
    send_item(32'hFFFF_FFFF, 16'shFFFF, 16'shFFFF);
    send_item(32'h8000_0000, SPEED_MIN, 16'sd0);
    send_item(32'h8000_0001, 16'sd0, SPEED_MIN);
  endtask

  // point at an eighth turn, then drive all three positions into both rails
  task automatic test_saturation();
    logic [drdo_pkg::MAG_W-1:0] turn;
    turn = 16'd8192 - odo_heading[31:16];
    send_item(odo_last_time + 32'd1000000, 16'sd0, turn);
    repeat (30) send_item(odo_last_time - 32'd1, SPEED_MAX, 16'sd0);
    repeat (60) send_item(odo_last_time - 32'd1, SPEED_MIN, 16'sd0);
  endtask

  task automatic test_pressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_CYCLES;
    repeat (12) send_random_item();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int count);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_random_item();
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_pose
    pose_t got;
    pose_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {x_pos_o, y_pos_o, distance_o, heading_o};
      results_seen++;
      if (longint'(x_pos_o) == POS_MAX || longint'(x_pos_o) == POS_MIN ||
          longint'(y_pos_o) == POS_MAX || longint'(y_pos_o) == POS_MIN ||
          longint'(distance_o) == POS_MAX || longint'(distance_o) == POS_MIN)
        rail_hits++;
      if (pose_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= SHOW_LIMIT)
          $display("%0t: result with no item pending: x %0d y %0d dist %0d hdg %0d",
                   $realtime, x_pos_o, y_pos_o, distance_o, heading_o);
      end else begin
        want = pose_q.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt <= SHOW_LIMIT) begin
            $display("%0t: result %0d mismatch", $realtime, results_seen);
            $display("  x    exp %0d got %0d", $signed(want.x), x_pos_o);
            $display("  y    exp %0d got %0d", $signed(want.y), y_pos_o);
            $display("  dist exp %0d got %0d", $signed(want.travel), distance_o);
            $display("  hdg  exp %0d got %0d", want.heading, heading_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    now_us_i        <= '0;
    forward_speed_i <= '0;
    turn_rate_i     <= '0;
    out_stall_i     <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    items_sent     = 0;
    results_seen   = 0;
    rail_hits      = 0;
    err_cnt        = 0;
    odo_last_time  = '0;
    odo_x          = 0;
    odo_y          = 0;
    odo_dist       = 0;
    odo_heading    = '0;
    for (int i = 0; i <= N; i++) sine_rom[i] = sine_q15(i);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_saturation();
    test_pressure();
    test_random_phase(0, 0, 205);
    test_random_phase(50, 0, 205);
    test_random_phase(0, 50, 205);
    test_random_phase(26, 26, 205);
    in_valid_i <= 1'b0;

    while (pose_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);

    $display("Sent %0d items: directed extremes, rail saturation, a %0d-cycle output hold",
             items_sent, HOLD_CYCLES);
    $display("and four idle mixes; %0d results checked, %0d at a rail, %0d errors",
             results_seen, rail_hits, err_cnt);
    if (err_cnt == 0 && pose_q.size() == 0) begin
      $display("[dead_reckoning_odometry_top] OK");
    end else begin
      $display("[dead_reckoning_odometry_top] ERROR");
    end
    $finish;
  end

endmodule
